[rtl/core/smpq_pkg.sv]
// Shared types and codes for the sorted message priority queue.
// Holds the entry layout, the operation and status codes and the cell control bundle.
// No dependencies.
package smpq_pkg;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] payload;
    } entry_t;

    // Broadcast to every cell in the chain each cycle
    typedef struct packed {
        logic   insert;     // place new_entry, shift the tail right
        logic   pop;        // shift everything one slot toward the head
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

[rtl/core/smpq_if.sv]
// Valid/ready channel interfaces for the sorted message priority queue.
// Depends on nothing; the payload fields follow the request and response beats.
interface smpq_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  task_id;
    logic [15:0] payload;

    modport source (output valid, output operation, output task_id, output payload,
                    input ready);
    modport sink   (input valid, input operation, input task_id, input payload,
                    output ready);
endinterface

interface smpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_task_id;
    logic [15:0] out_payload;
    logic [1:0]  status;
    logic [4:0]  occupancy;

    modport source (output valid, output out_task_id, output out_payload, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input out_task_id, input out_payload, input status,
                    input occupancy, output ready);
endinterface

[rtl/core/sorted_message_priority_queue_core.sv]
// Top level of the sorted message priority queue: cell chain, count and response register.
// Depends on smpq_pkg, smpq_if (smpq_req_if, smpq_rsp_if) and smpq_cell.
//
// Usage:
//   req carries one operation per beat: insert (task_id, payload) or pop.
//   rsp returns exactly one beat per request: the popped message (zero for
//   inserts and failures), a status code (done, insert dropped on full,
//   pop on empty) and the occupancy after the operation, masked to 5 bits.
//   Entries are kept ascending by task_id; a new message goes ahead of
//   existing entries with an equal task_id.
// Timing:
//   The response beat is registered at the edge that accepts the request.
//   Throughput is one request per cycle while the response register is free or
//   draining; every cell of the chain compares against the new key and shifts
//   in that same cycle, so the chain length does not change the rate.
// Stall and reset:
//   req.ready drops only while a response waits and rsp.ready is low; the
//   request is taken in the cycle the waiting response is taken.
//   Reset empties the queue (count to zero) and drops any pending response;
//   the slot contents are not cleared since slots at or above the count are
//   never read.
module sorted_message_priority_queue_core
#(
    parameter int DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    smpq_req_if.sink          req,
    smpq_rsp_if.source        rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [7:0]        rsp_task_reg;
    logic [7:0]        rsp_task_next;
    logic [15:0]       rsp_payload_reg;
    logic [15:0]       rsp_payload_next;
    smpq_pkg::status_t rsp_status_reg;
    smpq_pkg::status_t rsp_status_next;
    logic [4:0]        rsp_occ_reg;
    logic [4:0]        rsp_occ_next;

    logic accept;
    logic is_pop;
    logic full;
    logic empty;
    logic [CW+4:0] occ_ext;

    smpq_pkg::cell_ctrl_t ctrl;
    smpq_pkg::entry_t     ent  [DEPTH];
    logic                 keep [DEPTH];

    // Take a new request whenever the response register is free or draining
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_pop    = (smpq_pkg::op_t'(req.operation) == smpq_pkg::OP_POP);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    assign ctrl.insert            = accept && !is_pop && !full;
    assign ctrl.pop               = accept && is_pop && !empty;
    assign ctrl.new_entry.task_id = req.task_id;
    assign ctrl.new_entry.payload = req.payload;

    // Chain of slots, slot 0 is the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        smpq_cell u_cell
        (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (count_reg > CW'(i)),
            .prev_keep ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
            .left      (ent[(i == 0) ? 0 : i - 1]),
            .right     (ent[(i == DEPTH - 1) ? i : i + 1]),
            .keep      (keep[i]),
            .entry     (ent[i])
        );
    end

    always_comb
    begin
        count_next       = count_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_task_next    = rsp_task_reg;
        rsp_payload_next = rsp_payload_reg;
        rsp_status_next  = rsp_status_reg;

        if (ctrl.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CW'(1);
        end

        occ_ext      = {5'd0, count_next};
        rsp_occ_next = rsp_occ_reg;

        if (accept)
        begin
            rsp_valid_next   = 1'b1;
            rsp_task_next    = ctrl.pop ? ent[0].task_id : 8'd0;
            rsp_payload_next = ctrl.pop ? ent[0].payload : 16'd0;
            rsp_occ_next     = occ_ext[4:0];
            if (!is_pop && full)
            begin
                rsp_status_next = smpq_pkg::ST_FULL;
            end
            else if (is_pop && empty)
            begin
                rsp_status_next = smpq_pkg::ST_EMPTY;
            end
            else
            begin
                rsp_status_next = smpq_pkg::ST_DONE;
            end
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_task_reg    <= rsp_task_next;
        rsp_payload_reg <= rsp_payload_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_occ_reg     <= rsp_occ_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.out_task_id = rsp_task_reg;
    assign rsp.out_payload = rsp_payload_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.occupancy   = rsp_occ_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above capacity");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (ent[0].task_id <= ent[1].task_id))
        else $error("head slots out of order");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not advance the count");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_pop && empty) |=>
            (rsp.valid && rsp.status == smpq_pkg::ST_EMPTY && count_reg == '0))
        else $error("pop on empty queue not flagged");
`endif

endmodule

[rtl/core/smpq_cell.sv]
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on smpq_pkg.
module smpq_cell
(
    input  logic                   clk,
    input  smpq_pkg::cell_ctrl_t   ctrl,
    input  logic                   occupied,
    input  logic                   prev_keep,
    input  smpq_pkg::entry_t       left,
    input  smpq_pkg::entry_t       right,
    output logic                   keep,
    output smpq_pkg::entry_t       entry
);

    smpq_pkg::entry_t entry_reg;
    smpq_pkg::entry_t entry_next;

    // Hold on insert when this slot sorts strictly below the new key
    assign keep = occupied && (entry_reg.task_id < ctrl.new_entry.task_id);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (!keep)
            begin
                entry_next = prev_keep ? ctrl.new_entry : left;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[verif/tb_sorted_message_priority_queue_core.sv]
// Self-checking testbench for sorted_message_priority_queue_core.
// Depends on smpq_pkg, the smpq_req_if / smpq_rsp_if interfaces and the core RTL.
`timescale 1ns / 1ps

module tb_sorted_message_priority_queue_core;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;

    // Shadow of the sorted queue plus the replies it predicts, oldest first.
    typedef struct packed {
        logic [7:0]        task_id;
        logic [15:0]       payload;
        smpq_pkg::status_t status;
        logic [4:0]        occupancy;
    } reply_t;

    class message_order_scoreboard;
        smpq_pkg::entry_t shadow_queue[$];
        reply_t           pending_replies[$];
        int               capacity;
        int unsigned      failures;

        function new(int depth);
            capacity = depth;
            failures = 0;
        endfunction

        // Apply one accepted request beat to the shadow queue and log its reply.
        function void note_request(smpq_pkg::op_t op, smpq_pkg::entry_t msg);
            reply_t           reply;
            int               pos;
            smpq_pkg::entry_t head;
            reply = '{task_id: 8'd0, payload: 16'd0, status: smpq_pkg::ST_DONE,
                      occupancy: 5'd0};
            if (op == smpq_pkg::OP_INSERT)
            begin
                if (shadow_queue.size() >= capacity)
                begin
                    reply.status = smpq_pkg::ST_FULL;
                end
                else
                begin
                    // Land after every smaller key, ahead of equal keys
                    pos = 0;
                    while (pos < shadow_queue.size() && shadow_queue[pos].task_id < msg.task_id)
                        pos++;
                    shadow_queue.insert(pos, msg);
                end
            end
            else
            begin
                if (shadow_queue.size() == 0)
                begin
                    reply.status = smpq_pkg::ST_EMPTY;
                end
                else
                begin
                    head = shadow_queue.pop_front();
                    reply.task_id = head.task_id;
                    reply.payload = head.payload;
                end
            end
            reply.occupancy = 5'(shadow_queue.size());
            pending_replies.push_back(reply);
        endfunction

        function void check_reply(logic [7:0] task_id, logic [15:0] payload,
                                  logic [1:0] status, logic [4:0] occupancy);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                $error("response beat with no request outstanding: task %0d payload %0h",
                       task_id, payload);
                failures++;
                return;
            end
            want = pending_replies.pop_front();
            if (task_id !== want.task_id)
            begin
                $error("out_task_id: expected %0d, got %0d", want.task_id, task_id);
                failures++;
            end
            if (payload !== want.payload)
            begin
                $error("out_payload: expected %0h, got %0h", want.payload, payload);
                failures++;
            end
            if (status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, status);
                failures++;
            end
            if (occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    smpq_req_if req_ch();
    smpq_rsp_if rsp_ch();

    sorted_message_priority_queue_core #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    message_order_scoreboard order_check = new(QUEUE_DEPTH);

    // Idle percentages for each side; rsp_hold_left forces a long receiver stall.
    int src_idle_pct  = 0;
    int rsp_idle_pct  = 0;
    int rsp_hold_left = 0;
    int cycle_count   = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: end the run if the traffic never drains.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one request beat, optionally idling first; hold until accepted.
    // Valid stays high between back-to-back beats so it is never pulsed low.
    task automatic send_request(smpq_pkg::op_t op, logic [7:0] task_id,
                                logic [15:0] payload);
        smpq_pkg::entry_t msg;
        msg.task_id = task_id;
        msg.payload = payload;
        if ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.task_id   <= task_id;
        req_ch.payload   <= payload;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        order_check.note_request(op, msg);
    endtask

    // Short hand-picked sequence: empty pop, key and payload extremes, equal-key
    // ordering, filling to capacity and an insert that must be dropped.
    task automatic run_directed();
        send_request(smpq_pkg::OP_POP, 8'd0, 16'd0);
        send_request(smpq_pkg::OP_INSERT, 8'd0, 16'hFFFF);
        send_request(smpq_pkg::OP_INSERT, 8'd255, 16'h0000);
        send_request(smpq_pkg::OP_INSERT, 8'd255, 16'hFFFF);   // goes ahead of the older 255
        send_request(smpq_pkg::OP_INSERT, 8'd0, 16'h0000);     // goes ahead of the older 0
        send_request(smpq_pkg::OP_INSERT, 8'd128, 16'hA5A5);
        send_request(smpq_pkg::OP_POP, 8'hFF, 16'hFFFF);
        send_request(smpq_pkg::OP_POP, 8'h00, 16'h0000);
        // Descending keys push every new entry toward the head
        for (int i = 0; i < QUEUE_DEPTH - 3; i++)
            send_request(smpq_pkg::OP_INSERT, 8'(200 - 15 * i), 16'(16'h1111 * i));
        send_request(smpq_pkg::OP_INSERT, 8'd0, 16'h5A5A);     // full: drop
        send_request(smpq_pkg::OP_POP, 8'd0, 16'd0);
        send_request(smpq_pkg::OP_INSERT, 8'd1, 16'h8001);
    endtask

    // Bursts biased toward inserts, balanced, or biased toward pops, so the queue swings between
    // empty and full; some bursts use a narrow key window to force ties.
    task automatic run_random(int count);
        int            remaining;
        int            burst_len;
        int            insert_pct;
        bit            narrow_keys;
        logic [7:0]    key_base;
        logic [7:0]    key;
        smpq_pkg::op_t op;
        remaining = count;
        while (remaining > 0)
        begin
            burst_len = $urandom_range(60, 10);
            case ($urandom_range(2))
                0:       insert_pct = 15;
                1:       insert_pct = 50;
                default: insert_pct = 85;
            endcase
            narrow_keys = ($urandom_range(3) == 0);
            key_base = 8'($urandom_range(255));
            for (int n = 0; n < burst_len && remaining > 0; n++)
            begin
                op = ($urandom_range(99) < insert_pct) ? smpq_pkg::OP_INSERT
                                                       : smpq_pkg::OP_POP;
                if (narrow_keys)
                    key = key_base + 8'($urandom_range(3));
                else
                    key = 8'($urandom_range(255));
                send_request(op, key, 16'($urandom_range(16'hFFFF)));
                remaining--;
            end
        end
    endtask

    // Receiver: check each accepted response beat, then pick next ready.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                order_check.check_reply(rsp_ch.out_task_id, rsp_ch.out_payload,
                                        rsp_ch.status, rsp_ch.occupancy);
            if (rsp_hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    // Main sequence: reset, directed beats, three idle regimes, drain, verdict.
    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= smpq_pkg::OP_INSERT;
        req_ch.task_id   <= 8'd0;
        req_ch.payload   <= 16'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Sender idles lightly, receiver heavily
        src_idle_pct = 34;
        rsp_idle_pct = 86;
        run_random(517);

        // Swap the pressure
        src_idle_pct = 86;
        rsp_idle_pct = 34;
        run_random(517);

        // No idling; hold the receiver off long enough to back up the input
        src_idle_pct  = 0;
        rsp_idle_pct  = 0;
        rsp_hold_left = 120;
        run_random(493);

        req_ch.valid <= 1'b0;
        while (order_check.outstanding() != 0)
            @(posedge clk);
        // Let any stray response beat surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (order_check.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
